[sv/lev_pkg.sv]
// shared constants, types and helper functions for the levenshtein distance engine
// no dependencies
package lev_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int COST_W  = LEN_W;
    localparam int CH_W    = 8;
    localparam int FUNC_W  = 2;
    localparam int DIST_W  = 7;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND_FIRST  = 2'd0,
        FUNC_APPEND_SECOND = 2'd1,
        FUNC_COMPUTE       = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_CELL,
        ST_DRAIN,
        ST_DONE
    } state_t;

    function automatic logic [COST_W-1:0] min3(
        input logic [COST_W-1:0] a,
        input logic [COST_W-1:0] b,
        input logic [COST_W-1:0] c
    );
        logic [COST_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [DIST_W-1:0] sat_dist(input logic [COST_W-1:0] v);
        if (int'(v) > int'(DIST_MAX)) begin
            return DIST_MAX;
        end
        return DIST_W'(v);
    endfunction

endpackage

[sv/levenshtein_distance_engine_core.sv]
// top level of the levenshtein distance engine: sequencer, cell datapath and result register
// depends on lev_pkg and lev_ram
//
// Append beats (func 0 and 1) are taken one per cycle and written straight into the two
// character memories; a string holding MAX_LEN characters drops further characters and sets
// the overflow flag. A compute beat (func 2) walks the edit-distance grid one cell per cycle
// through a single cost-row memory (registered read, write-back in the cycle after the read),
// with an extra row state per row to fetch that row's character. With both strings non-empty
// the result passes the drain and done states after the last cell; with either string empty
// the compute beat goes straight to the done state. No new beat is taken until the result has
// been moved into the output register, which holds it until the sink takes it. Func 3 is taken
// and ignored. After a compute both lengths and the overflow flag are cleared.
module levenshtein_distance_engine_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lev_pkg::FUNC_W-1:0]   s_func,
    input  logic [lev_pkg::CH_W-1:0]     s_ch,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lev_pkg::DIST_W-1:0]   m_distance,
    output logic                         m_overflow
);
    import lev_pkg::*;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    first_len_reg, first_len_next;
    logic [LEN_W-1:0]    second_len_reg, second_len_next;
    logic                trunc_reg, trunc_next;
    logic [LEN_W-1:0]    i_reg, i_next;
    logic [LEN_W-1:0]    j_reg, j_next;
    logic [DIST_W-1:0]   res_reg, res_next;

    logic                cval_reg, cval_next;
    logic [LEN_W-1:0]    c_i_reg, c_i_next;
    logic [LEN_W-1:0]    c_j_reg, c_j_next;
    logic                c_last_reg, c_last_next;
    logic [COST_W-1:0]   left_reg, left_next;
    logic [COST_W-1:0]   diag_reg, diag_next;

    logic                m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]   m_distance_reg, m_distance_next;
    logic                m_overflow_reg, m_overflow_next;

    logic                s_acc;
    logic                out_free;
    logic [LEN_W-1:0]    i_dec, j_dec, cj_dec;

    logic                first_we, first_re;
    logic [IDX_W-1:0]    first_waddr, first_raddr;
    logic [CH_W-1:0]     first_rdata;
    logic                second_we, second_re;
    logic [IDX_W-1:0]    second_waddr, second_raddr;
    logic [CH_W-1:0]     second_rdata;
    logic                cost_we, cost_re;
    logic [IDX_W-1:0]    cost_waddr, cost_raddr;
    logic [COST_W-1:0]   cost_wdata, cost_rdata;

    logic [COST_W-1:0]   above, left, diag, cell_cost;

    // memories
    lev_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_first_text (
        .clk   (aclk),
        .we    (first_we),
        .waddr (first_waddr),
        .wdata (s_ch),
        .re    (first_re),
        .raddr (first_raddr),
        .rdata (first_rdata)
    );

    lev_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_second_text (
        .clk   (aclk),
        .we    (second_we),
        .waddr (second_waddr),
        .wdata (s_ch),
        .re    (second_re),
        .raddr (second_raddr),
        .rdata (second_rdata)
    );

    // entry k holds column k+1 of the current row; column 0 is implied by the row number
    lev_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN)) u_cost_row (
        .clk   (aclk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .re    (cost_re),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    // cell datapath
    always_comb begin
        above = (c_i_reg == LEN_W'(1)) ? COST_W'(c_j_reg) : cost_rdata;
        left  = (c_j_reg == LEN_W'(1)) ? COST_W'(c_i_reg) : left_reg;
        diag  = (c_j_reg == LEN_W'(1)) ? COST_W'(c_i_reg - LEN_W'(1)) : diag_reg;
        if (first_rdata == second_rdata) begin
            cell_cost = diag;
        end else begin
            cell_cost = min3(above, left, diag) + COST_W'(1);
        end
    end

    // outputs and memory controls
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        s_acc        = s_valid && (state_reg == ST_IDLE);
        out_free     = !m_valid_reg || m_ready;
        i_dec        = i_reg - LEN_W'(1);
        j_dec        = j_reg - LEN_W'(1);
        cj_dec       = c_j_reg - LEN_W'(1);

        first_we     = s_acc && (s_func == FUNC_APPEND_FIRST)
                       && (first_len_reg < LEN_W'(MAX_LEN));
        first_waddr  = first_len_reg[IDX_W-1:0];
        first_re     = (state_reg == ST_ROW);
        first_raddr  = i_dec[IDX_W-1:0];

        second_we    = s_acc && (s_func == FUNC_APPEND_SECOND)
                       && (second_len_reg < LEN_W'(MAX_LEN));
        second_waddr = second_len_reg[IDX_W-1:0];
        second_re    = (state_reg == ST_CELL);
        second_raddr = j_dec[IDX_W-1:0];

        cost_re      = (state_reg == ST_CELL);
        cost_raddr   = j_dec[IDX_W-1:0];
        cost_we      = cval_reg;
        cost_waddr   = cj_dec[IDX_W-1:0];
        cost_wdata   = cell_cost;

        m_valid      = m_valid_reg;
        m_distance   = m_distance_reg;
        m_overflow   = m_overflow_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_func == FUNC_COMPUTE)) begin
                    if ((first_len_reg == '0) || (second_len_reg == '0)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW: begin
                state_next = ST_CELL;
            end
            ST_CELL: begin
                if (j_reg == second_len_reg) begin
                    state_next = (i_reg == first_len_reg) ? ST_DRAIN : ST_ROW;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        trunc_next      = trunc_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        res_next        = res_reg;
        left_next       = left_reg;
        diag_next       = diag_reg;
        m_valid_next    = m_valid_reg;
        m_distance_next = m_distance_reg;
        m_overflow_next = m_overflow_reg;

        cval_next       = (state_reg == ST_CELL);
        c_i_next        = i_reg;
        c_j_next        = j_reg;
        c_last_next     = (i_reg == first_len_reg) && (j_reg == second_len_reg);

        if (s_acc) begin
            unique case (s_func)
                FUNC_APPEND_FIRST: begin
                    if (first_len_reg < LEN_W'(MAX_LEN)) begin
                        first_len_next = first_len_reg + LEN_W'(1);
                    end else begin
                        trunc_next = 1'b1;
                    end
                end
                FUNC_APPEND_SECOND: begin
                    if (second_len_reg < LEN_W'(MAX_LEN)) begin
                        second_len_next = second_len_reg + LEN_W'(1);
                    end else begin
                        trunc_next = 1'b1;
                    end
                end
                FUNC_COMPUTE: begin
                    i_next = LEN_W'(1);
                    if (first_len_reg == '0) begin
                        res_next = sat_dist(COST_W'(second_len_reg));
                    end else begin
                        res_next = sat_dist(COST_W'(first_len_reg));
                    end
                end
                default: begin
                end
            endcase
        end

        if (state_reg == ST_ROW) begin
            j_next = LEN_W'(1);
        end

        if (state_reg == ST_CELL) begin
            if (j_reg == second_len_reg) begin
                i_next = i_reg + LEN_W'(1);
            end else begin
                j_next = j_reg + LEN_W'(1);
            end
        end

        if (cval_reg) begin
            left_next = cell_cost;
            diag_next = above;
            if (c_last_reg) begin
                res_next = sat_dist(cell_cost);
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if ((state_reg == ST_DONE) && out_free) begin
            m_valid_next    = 1'b1;
            m_distance_next = res_reg;
            m_overflow_next = trunc_reg;
            first_len_next  = '0;
            second_len_next = '0;
            trunc_next      = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            trunc_reg      <= 1'b0;
            cval_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            trunc_reg      <= trunc_next;
            cval_reg       <= cval_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        res_reg        <= res_next;
        c_i_reg        <= c_i_next;
        c_j_reg        <= c_j_next;
        c_last_reg     <= c_last_next;
        left_reg       <= left_next;
        diag_reg       <= diag_next;
        m_distance_reg <= m_distance_next;
        m_overflow_reg <= m_overflow_next;
    end

    // checks
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_len_reg <= LEN_W'(MAX_LEN)) && (second_len_reg <= LEN_W'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CELL) |-> ((j_reg != '0) && (j_reg <= second_len_reg)))
        else $error("column counter out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW) |-> ((i_reg != '0) && (i_reg <= first_len_reg)))
        else $error("row counter out of range");

    a_cell_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CELL) |=> cval_reg)
        else $error("cell write-back missing after read");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside completion");

endmodule

[sv/lev_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module lev_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/tb_levenshtein_distance_engine_core.sv]
// self-checking testbench for levenshtein_distance_engine_core: loads string pairs, computes
// edit distances and checks every result against a scoreboard holding its own string copies
// depends on lev_pkg and the levenshtein_distance_engine_core rtl
module tb_levenshtein_distance_engine_core;
    import lev_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_BEATS   = 650;
    localparam int IDLE_LIMIT     = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int CHARS_LETTERS  = 0;
    localparam int CHARS_ANY      = 1;
    localparam int CHARS_EXTREME  = 2;
    localparam int CHARS_DISJOINT = 3;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } edit_result_t;

    class distance_scoreboard;
        logic [CH_W-1:0] first_chars[MAX_LEN];
        logic [CH_W-1:0] second_chars[MAX_LEN];
        int              first_len;
        int              second_len;
        bit              dropped;
        edit_result_t    pending_q[$];
        int              errors;
        int              results_checked;
        int              widest_distance;
        int              overflow_results;
        int              ignored_beats;

        function new();
            first_len = 0;
            second_len = 0;
            dropped = 0;
            errors = 0;
            results_checked = 0;
            widest_distance = 0;
            overflow_results = 0;
            ignored_beats = 0;
        endfunction

        function int edit_distance();
            int prev_row[MAX_LEN+1];
            int this_row[MAX_LEN+1];
            int diag_cost;
            int i;
            int j;
            if (first_len == 0) return second_len;
            if (second_len == 0) return first_len;
            for (j = 0; j <= second_len; j++) prev_row[j] = j;
            for (i = 1; i <= first_len; i++) begin
                this_row[0] = i;
                for (j = 1; j <= second_len; j++) begin
                    if (first_chars[i-1] == second_chars[j-1]) begin
                        this_row[j] = prev_row[j-1];
                    end else begin
                        diag_cost = prev_row[j-1] + 1;
                        this_row[j] = prev_row[j] + 1;
                        if (this_row[j-1] + 1 < this_row[j]) this_row[j] = this_row[j-1] + 1;
                        if (diag_cost < this_row[j]) this_row[j] = diag_cost;
                    end
                end
                prev_row = this_row;
            end
            return prev_row[second_len];
        endfunction

        function void note_beat(logic [FUNC_W-1:0] func, logic [CH_W-1:0] ch);
            edit_result_t want;
            int d;
            case (func)
                FUNC_APPEND_FIRST: begin
                    if (first_len < MAX_LEN) begin
                        first_chars[first_len] = ch;
                        first_len++;
                    end else begin
                        dropped = 1;
                    end
                end
                FUNC_APPEND_SECOND: begin
                    if (second_len < MAX_LEN) begin
                        second_chars[second_len] = ch;
                        second_len++;
                    end else begin
                        dropped = 1;
                    end
                end
                FUNC_COMPUTE: begin
                    d = edit_distance();
                    if (d > int'(DIST_MAX)) d = int'(DIST_MAX);
                    want.distance = DIST_W'(d);
                    want.overflow = dropped;
                    pending_q = {pending_q, want};
                    first_len = 0;
                    second_len = 0;
                    dropped = 0;
                end
                default: ignored_beats++;
            endcase
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [DIST_W-1:0] distance, logic overflow);
            edit_result_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result distance %0d overflow %0b",
                                 distance, overflow));
            end else begin
                want = pending_q.pop_front();
                results_checked++;
                if (distance !== want.distance)
                    report($sformatf("distance %0d, expected %0d", distance, want.distance));
                if (overflow !== want.overflow)
                    report($sformatf("overflow %0b, expected %0b", overflow, want.overflow));
                if (int'(want.distance) > widest_distance)
                    widest_distance = int'(want.distance);
                if (want.overflow) overflow_results++;
            end
        endtask

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [FUNC_W-1:0] s_func = '0;
    logic [CH_W-1:0]   s_ch = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DIST_W-1:0] m_distance;
    logic              m_overflow;

    distance_scoreboard sb;

    int beats_sent = 0;
    int tx_burst_left = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int holds_done = 0;
    int drains_done = 0;
    int rx_run_left = 0;
    bit rx_level = 1'b1;
    bit next_ready;
    int idle_count = 0;

    levenshtein_distance_engine_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_ch       (s_ch),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance),
        .m_overflow (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [CH_W-1:0] ch);
        int gap;
        if (tx_burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                gap = 0;
                tx_burst_left = $urandom_range(30, 100);
            end else begin
                gap = $urandom_range(0, 12);
                tx_burst_left = $urandom_range(1, 8);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        tx_burst_left--;
        s_valid <= 1'b1;
        s_func <= func;
        s_ch <= ch;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(func, ch);
        if (func != FUNC_UNUSED) beats_sent++;
    endtask

    function automatic logic [CH_W-1:0] pick_char(input int chars, input bit second);
        case (chars)
            CHARS_LETTERS:  return CH_W'(8'h61 + $urandom_range(0, 3));
            CHARS_EXTREME:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            CHARS_DISJOINT: return second ? CH_W'($urandom_range(8'h80, 8'hFF))
                                          : CH_W'($urandom_range(8'h00, 8'h3F));
            default:        return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // interleaves the two strings' appends at random, then asks for the distance
    task automatic load_and_compute(input int n, input int m, input int chars, input bit alike);
        logic [CH_W-1:0] first_q[$];
        logic [CH_W-1:0] second_q[$];
        int k;
        int ia;
        int ib;
        for (k = 0; k < n; k++) first_q = {first_q, pick_char(chars, 1'b0)};
        for (k = 0; k < m; k++) begin
            if (alike && k < n && $urandom_range(0, 3) != 0) second_q = {second_q, first_q[k]};
            else second_q = {second_q, pick_char(chars, 1'b1)};
        end
        ia = 0;
        ib = 0;
        while (ia < n || ib < m) begin
            if ($urandom_range(0, 29) == 0) send_beat(FUNC_UNUSED, pick_char(CHARS_ANY, 1'b0));
            if (ib >= m || (ia < n && $urandom_range(0, 1) == 1)) begin
                send_beat(FUNC_APPEND_FIRST, first_q[ia]);
                ia++;
            end else begin
                send_beat(FUNC_APPEND_SECOND, second_q[ib]);
                ib++;
            end
        end
        send_beat(FUNC_COMPUTE, pick_char(CHARS_ANY, 1'b0));
        if ($urandom_range(0, 19) == 0) send_beat(FUNC_COMPUTE, pick_char(CHARS_ANY, 1'b0));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
        drains_done++;
    endtask

    // output side: own stall pattern, plus long hold-offs on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_distance, m_overflow);
        if (!aresetn) begin
            next_ready = 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            next_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            next_ready = 1'b0;
        end else begin
            if (rx_run_left == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        rx_level = 1'b1;
                        rx_run_left = $urandom_range(20, 80);
                    end
                    1, 2: begin
                        rx_level = 1'b0;
                        rx_run_left = $urandom_range(1, 15);
                    end
                    default: begin
                        rx_level = 1'b1;
                        rx_run_left = $urandom_range(1, 10);
                    end
                endcase
            end
            rx_run_left--;
            next_ready = rx_level;
        end
        m_ready <= next_ready;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count = 0;
            else idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int seq;
        int roll;
        int n;
        int m;
        int chars;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty strings, extreme bytes, ignored selector, match, replace, delete
        send_beat(FUNC_COMPUTE, 8'h00);
        send_beat(FUNC_UNUSED, 8'hA5);
        send_beat(FUNC_APPEND_FIRST, 8'hFF);
        send_beat(FUNC_COMPUTE, 8'hFF);
        send_beat(FUNC_APPEND_SECOND, 8'h00);
        send_beat(FUNC_APPEND_SECOND, 8'h7F);
        send_beat(FUNC_COMPUTE, 8'h55);
        send_beat(FUNC_APPEND_FIRST, 8'h00);
        send_beat(FUNC_APPEND_SECOND, 8'h00);
        send_beat(FUNC_COMPUTE, 8'hAA);
        send_beat(FUNC_APPEND_FIRST, 8'hFF);
        send_beat(FUNC_UNUSED, 8'hFF);
        send_beat(FUNC_APPEND_SECOND, 8'hFE);
        send_beat(FUNC_COMPUTE, 8'h00);
        send_beat(FUNC_APPEND_FIRST, "a");
        send_beat(FUNC_APPEND_FIRST, "b");
        send_beat(FUNC_APPEND_SECOND, "a");
        send_beat(FUNC_APPEND_FIRST, "c");
        send_beat(FUNC_APPEND_SECOND, "c");
        send_beat(FUNC_COMPUTE, 8'h01);

        seq = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (seq == 2) begin
                load_and_compute(MAX_LEN + 2, 0, CHARS_ANY, 1'b0);
            end else if (seq == 5) begin
                load_and_compute(MAX_LEN, MAX_LEN + 1, CHARS_DISJOINT, 1'b0);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    n = $urandom_range(50, MAX_LEN + 2);
                    m = $urandom_range(50, MAX_LEN + 2);
                end else if (roll < 12) begin
                    n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    m = (n == 0) ? $urandom_range(0, 8) : 0;
                end else begin
                    n = $urandom_range(1, 10);
                    m = $urandom_range(1, 10);
                end
                roll = $urandom_range(0, 9);
                chars = (roll < 5) ? CHARS_LETTERS : (roll < 8) ? CHARS_ANY : CHARS_EXTREME;
                load_and_compute(n, m, chars, $urandom_range(0, 2) == 0);
            end
            if (seq == 8 || seq == 30) begin
                hold_token <= hold_token + 1;
                holds_done++;
                tx_burst_left = 60;
            end
            if (seq == 15 || seq == 40) drain_results();
            seq++;
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d load and compute beats, %0d ignored beats,",
                 beats_sent, sb.ignored_beats);
        $display("%0d long output holds, %0d full drains, %0d distances checked up to %0d,",
                 holds_done, drains_done, sb.results_checked, sb.widest_distance);
        $display("%0d of them truncated, %0d mismatches", sb.overflow_results, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
